FILE: rtl/text_console_char_writer_defines.svh
// ---------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property at every rising edge outside reset.
`define TCW_ASSERT(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("tcw assertion failed");
// Check that a condition implies another in the same cycle.
`define TCW_ASSERT_IMPLY(label, clock, reset, cond, conseq) \
  `TCW_ASSERT(label, clock, reset, (cond) |-> (conseq))
`else
`define TCW_ASSERT(label, clock, reset, prop)
`define TCW_ASSERT_IMPLY(label, clock, reset, cond, conseq)
`endif

`endif

FILE: rtl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, codes and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int SCREEN_SIZE = ROWS * COLUMNS;
  localparam int LAST_ROW    = (ROWS - 1) * COLUMNS;

  localparam int OP_W     = 2;
  localparam int CH_W     = 8;
  localparam int IDX_W    = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;
  localparam int ADDR_W   = $clog2(SCREEN_SIZE);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int SWEEP_W  = $clog2(SCREEN_SIZE + 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]        TEXT_ATTR    = 8'h07;
  localparam logic [CH_W-1:0]   CH_NEWLINE   = 8'd10;
  localparam logic [CH_W-1:0]   CH_RETURN    = 8'd13;
  localparam logic [CH_W-1:0]   CH_BACKSPACE = 8'd8;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_PRINT,
    K_NEWLINE,
    K_RETURN,
    K_BACKSPACE,
    K_CLEAR,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CH_W-1:0]   ch;
    logic [ADDR_W-1:0] addr;
    logic              in_range;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_ctrl_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/text_console_char_writer.sv
// ---------------------------------------------------------------------------
// Text console character writer
// Screen buffer with cursor, put/clear/read commands on a stream interface.
// ---------------------------------------------------------------------------
// The block keeps a ROWS x COLUMNS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) in one RAM, and a cursor. Every input
// word gives exactly one output word. After reset a clearing pass writes the
// blank cell 0x0720 into all SCREEN_SIZE cells while s_axis_tready stays low.
// An ordinary put, newline, carriage return, backspace or unused opcode goes
// from idle to the done state; an on-screen read passes a read state for the
// registered RAM read; a clear blanks every cell and a put that scrolls moves
// every row up and blanks the bottom row, both by the single RAM write port,
// which moves or blanks one cell a cycle. A two-word queue sits between the
// front end and the execution unit, and the result sits in an output
// register, so the input keeps taking words while a result waits.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [1:0] opcode, [9:2] char_code, [20:10] cell_index, [23:21] zero
  input  wire logic [tcw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [10:0] cursor_position, [26:11] cell_value, [27] scrolled, [31:28] zero
  output logic [tcw_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  tcw_pkg::cmd_t                   push_cmd;
  tcw_pkg::cmd_t                   head_cmd;
  tcw_pkg::queue_ctrl_t            qctl;
  logic                            init_busy;
  logic [tcw_pkg::CURSOR_W-1:0]    cursor_position;
  logic [tcw_pkg::CELL_W-1:0]      cell_value;
  logic                            scrolled;

  // Classify the incoming word
  tcw_front u_front (
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .opcode     (s_axis_tdata[1:0]),
    .char_code  (s_axis_tdata[9:2]),
    .cell_index (s_axis_tdata[20:10]),
    .init_busy  (init_busy),
    .queue_full (qctl.full),
    .push       (qctl.push),
    .cmd        (push_cmd)
  );

  // Hold classified commands until the back end takes them
  tcw_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (qctl.push),
    .pop   (qctl.pop),
    .din   (push_cmd),
    .dout  (head_cmd),
    .full  (qctl.full),
    .empty (qctl.empty)
  );

  // Carry out commands on the screen and the cursor
  tcw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head_cmd),
    .queue_empty  (qctl.empty),
    .pop          (qctl.pop),
    .init_busy    (init_busy),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_cursor   (cursor_position),
    .out_value    (cell_value),
    .out_scrolled (scrolled)
  );

  // Pack the result word, upper bits zero
  assign m_axis_tdata = {4'b0000, scrolled, cell_value, cursor_position};

endmodule

`default_nettype wire

FILE: rtl/tcw_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_fifo.sv
// ---------------------------------------------------------------------------
// Command queue
// Short register queue between the front and the back of the writer.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic              pop,
  input  wire tcw_pkg::cmd_t     din,
  output tcw_pkg::cmd_t          dout,
  output logic                   full,
  output logic                   empty
);

  tcw_pkg::cmd_t                  q [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0]     count;

  function automatic logic [tcw_pkg::QPTR_W-1:0] bump(input logic [tcw_pkg::QPTR_W-1:0] p);
    if (p == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full  = (count == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_front.sv
// ---------------------------------------------------------------------------
// Command front end
// Accept input words, classify them and push them into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_front (
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [tcw_pkg::OP_W-1:0]   opcode,
  input  wire logic [tcw_pkg::CH_W-1:0]   char_code,
  input  wire logic [tcw_pkg::IDX_W-1:0]  cell_index,
  input  wire logic                       init_busy,
  input  wire logic                       queue_full,
  output logic                            push,
  output tcw_pkg::cmd_t                   cmd
);

  tcw_pkg::kind_t kind;

  always_comb begin
    unique case (tcw_pkg::op_t'(opcode))
      tcw_pkg::OP_PUT: begin
        if (char_code == tcw_pkg::CH_NEWLINE) begin
          kind = tcw_pkg::K_NEWLINE;
        end else if (char_code == tcw_pkg::CH_RETURN) begin
          kind = tcw_pkg::K_RETURN;
        end else if (char_code == tcw_pkg::CH_BACKSPACE) begin
          kind = tcw_pkg::K_BACKSPACE;
        end else begin
          kind = tcw_pkg::K_PRINT;
        end
      end
      tcw_pkg::OP_CLEAR: kind = tcw_pkg::K_CLEAR;
      tcw_pkg::OP_READ:  kind = tcw_pkg::K_READ;
      default:           kind = tcw_pkg::K_NOP;
    endcase
  end

  assign in_ready     = !queue_full && !init_busy;
  assign push         = in_valid && in_ready;
  assign cmd.kind     = kind;
  assign cmd.ch       = char_code;
  assign cmd.addr     = tcw_pkg::ADDR_W'(cell_index);
  assign cmd.in_range = (32'(cell_index) < 32'(tcw_pkg::SCREEN_SIZE));

endmodule

`default_nettype wire

FILE: rtl/tcw_back.sv
// ---------------------------------------------------------------------------
// Command back end
// Execute queued commands on the screen memory and the cursor.
// ---------------------------------------------------------------------------
`default_nettype none

`include "text_console_char_writer_defines.svh"

module tcw_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tcw_pkg::cmd_t                 head,
  input  wire logic                          queue_empty,
  output logic                               pop,
  output logic                               init_busy,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tcw_pkg::CURSOR_W-1:0]       out_cursor,
  output logic [tcw_pkg::CELL_W-1:0]         out_value,
  output logic                               out_scrolled
);

  tcw_pkg::state_t                 state;
  tcw_pkg::state_t                 state_next;
  logic [tcw_pkg::CURSOR_W-1:0]    cursor;
  logic [tcw_pkg::COL_W-1:0]       col;
  logic [tcw_pkg::SWEEP_W-1:0]     sweep;
  logic [tcw_pkg::CELL_W-1:0]      value;
  logic                            scrolled;

  logic [tcw_pkg::CURSOR_W-1:0]    row_base;
  logic [tcw_pkg::CURSOR_W:0]      put_cur;
  logic [tcw_pkg::COL_W-1:0]       put_col;
  logic                            put_scroll;
  logic                            is_put;
  logic                            out_free;

  logic                            ram_we;
  logic [tcw_pkg::ADDR_W-1:0]      ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]      ram_wdata;
  logic                            ram_re;
  logic [tcw_pkg::ADDR_W-1:0]      ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]      ram_rdata;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::SCREEN_SIZE)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid || out_ready;
  assign init_busy = (state == tcw_pkg::ST_INIT);
  assign row_base  = cursor - tcw_pkg::CURSOR_W'(col);

  // Cursor move of a put command, before the scroll check
  always_comb begin
    is_put  = 1'b1;
    put_cur = {1'b0, cursor};
    put_col = col;
    case (head.kind)
      tcw_pkg::K_PRINT: begin
        put_cur = {1'b0, cursor} + 1'b1;
        put_col = (col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) ? '0 : col + 1'b1;
      end
      tcw_pkg::K_NEWLINE: begin
        put_cur = {1'b0, row_base} + (tcw_pkg::CURSOR_W + 1)'(tcw_pkg::COLUMNS);
        put_col = '0;
      end
      tcw_pkg::K_RETURN: begin
        put_cur = {1'b0, row_base};
        put_col = '0;
      end
      tcw_pkg::K_BACKSPACE: begin
        if (cursor != '0) begin
          put_cur = {1'b0, cursor} - 1'b1;
          put_col = (col == '0) ? tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1) : col - 1'b1;
        end
      end
      default: is_put = 1'b0;
    endcase
  end

  assign put_scroll = (32'(put_cur) >= 32'(tcw_pkg::SCREEN_SIZE));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        if (sweep == tcw_pkg::SWEEP_W'(tcw_pkg::SCREEN_SIZE - 1)) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (!queue_empty) begin
          if (is_put) begin
            state_next = put_scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_DONE;
          end else if (head.kind == tcw_pkg::K_CLEAR) begin
            state_next = tcw_pkg::ST_BLANK;
          end else if (head.kind == tcw_pkg::K_READ && head.in_range) begin
            state_next = tcw_pkg::ST_READ;
          end else begin
            state_next = tcw_pkg::ST_DONE;
          end
        end
      end
      tcw_pkg::ST_READ: state_next = tcw_pkg::ST_DONE;
      tcw_pkg::ST_SCROLL: begin
        if (sweep == tcw_pkg::SWEEP_W'(tcw_pkg::SCREEN_SIZE)) begin
          state_next = tcw_pkg::ST_BLANK;
        end
      end
      tcw_pkg::ST_BLANK: begin
        if (sweep == tcw_pkg::SWEEP_W'(tcw_pkg::SCREEN_SIZE - 1)) begin
          state_next = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: state_next = tcw_pkg::ST_INIT;
    endcase
  end

  // Memory and queue controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tcw_pkg::ADDR_W'(sweep);
    ram_wdata = tcw_pkg::BLANK_CELL;
    ram_re    = 1'b0;
    ram_raddr = head.addr;
    pop       = 1'b0;
    unique case (state)
      tcw_pkg::ST_INIT, tcw_pkg::ST_BLANK: begin
        ram_we = 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        pop = !queue_empty;
        if (!queue_empty && head.kind == tcw_pkg::K_PRINT) begin
          ram_we    = 1'b1;
          ram_waddr = tcw_pkg::ADDR_W'(cursor);
          ram_wdata = {tcw_pkg::TEXT_ATTR, head.ch};
        end
        if (!queue_empty && head.kind == tcw_pkg::K_READ && head.in_range) begin
          ram_re = 1'b1;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        ram_re    = (sweep < tcw_pkg::SWEEP_W'(tcw_pkg::SCREEN_SIZE));
        ram_raddr = tcw_pkg::ADDR_W'(sweep);
        ram_we    = (sweep > tcw_pkg::SWEEP_W'(tcw_pkg::COLUMNS));
        ram_waddr = tcw_pkg::ADDR_W'(sweep - tcw_pkg::SWEEP_W'(tcw_pkg::COLUMNS + 1));
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::ST_INIT;
      sweep     <= '0;
      cursor    <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tcw_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        tcw_pkg::ST_INIT, tcw_pkg::ST_BLANK: begin
          sweep <= sweep + 1'b1;
        end
        tcw_pkg::ST_IDLE: begin
          if (!queue_empty) begin
            value    <= '0;
            scrolled <= is_put && put_scroll;
            if (is_put) begin
              if (put_scroll) begin
                cursor   <= tcw_pkg::CURSOR_W'(tcw_pkg::LAST_ROW);
                col      <= '0;
                sweep    <= tcw_pkg::SWEEP_W'(tcw_pkg::COLUMNS);
              end else begin
                cursor <= tcw_pkg::CURSOR_W'(put_cur);
                col    <= put_col;
              end
            end else if (head.kind == tcw_pkg::K_CLEAR) begin
              cursor <= '0;
              col    <= '0;
              sweep  <= '0;
            end
          end
        end
        tcw_pkg::ST_READ: begin
          value <= ram_rdata;
        end
        tcw_pkg::ST_SCROLL: begin
          if (sweep == tcw_pkg::SWEEP_W'(tcw_pkg::SCREEN_SIZE)) begin
            sweep <= tcw_pkg::SWEEP_W'(tcw_pkg::LAST_ROW);
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        tcw_pkg::ST_DONE: begin
          if (out_free) begin
            out_cursor   <= cursor;
            out_value    <= value;
            out_scrolled <= scrolled;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `TCW_ASSERT(a_cursor_on_screen, clk, rst,
    32'(cursor) < 32'(tcw_pkg::SCREEN_SIZE))
  `TCW_ASSERT(a_col_in_row, clk, rst, 32'(col) < 32'(tcw_pkg::COLUMNS))
  `TCW_ASSERT_IMPLY(a_scroll_cursor_last_row, clk, rst, state == tcw_pkg::ST_SCROLL,
    cursor == tcw_pkg::CURSOR_W'(tcw_pkg::LAST_ROW))
  `TCW_ASSERT_IMPLY(a_copy_no_overlap, clk, rst, ram_we && ram_re, ram_waddr != ram_raddr)

endmodule

`default_nettype wire

FILE: verif/tcw_scoreboard_pkg.sv
// ---------------------------------------------------------------------------
// Text console writer scoreboard
// Mirrors the screen and cursor, queues the expected result words and
// compares the block's results against them field by field.
// ---------------------------------------------------------------------------
package tcw_scoreboard_pkg;

  import tcw_pkg::*;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CELL_W-1:0]   cell_value;
    logic                scrolled;
  } console_reply_t;

  class console_scoreboard;
    logic [CELL_W-1:0] screen [SCREEN_SIZE];
    int unsigned       cursor;
    console_reply_t    replies_due [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       puts;
    int unsigned       scrolls;
    int unsigned       clears;
    int unsigned       reads;
    int unsigned       wild_reads;
    int unsigned       unused_ops;

    function new();
      foreach (screen[i]) screen[i] = BLANK_CELL;
      cursor     = 0;
      errors     = 0;
      checked    = 0;
      puts       = 0;
      scrolls    = 0;
      clears     = 0;
      reads      = 0;
      wild_reads = 0;
      unused_ops = 0;
    endfunction

    // Apply one accepted command word to the mirror and queue its result.
    function void note_command(logic [IN_DATA_W-1:0] word);
      op_t             op;
      logic [CH_W-1:0] ch;
      int unsigned     idx;
      int unsigned     pos;
      console_reply_t  reply;
      op    = op_t'(word[OP_W-1:0]);
      ch    = word[OP_W +: CH_W];
      idx   = word[OP_W+CH_W +: IDX_W];
      reply = '0;
      case (op)
        OP_PUT: begin
          puts++;
          pos = cursor;
          if (pos >= SCREEN_SIZE) pos = 0;
          case (ch)
            CH_NEWLINE:   pos = pos + COLUMNS - pos % COLUMNS;
            CH_RETURN:    pos = pos - pos % COLUMNS;
            CH_BACKSPACE: if (pos > 0) pos = pos - 1;
            default: begin
              screen[pos] = {TEXT_ATTR, ch};
              pos = pos + 1;
            end
          endcase
          if (pos >= SCREEN_SIZE) begin
            // Move every row up by one and blank the bottom row
            for (int i = 0; i < LAST_ROW; i++) screen[i] = screen[i + COLUMNS];
            for (int i = LAST_ROW; i < SCREEN_SIZE; i++) screen[i] = BLANK_CELL;
            cursor         = LAST_ROW;
            reply.scrolled = 1'b1;
            scrolls++;
          end else begin
            cursor = pos;
          end
        end
        OP_CLEAR: begin
          clears++;
          foreach (screen[i]) screen[i] = BLANK_CELL;
          cursor = 0;
        end
        OP_READ: begin
          reads++;
          if (idx < SCREEN_SIZE) reply.cell_value = screen[idx];
          else wild_reads++;
        end
        default: unused_ops++;
      endcase
      reply.cursor = cursor[CURSOR_W-1:0];
      replies_due.push_back(reply);
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_reply(logic [OUT_DATA_W-1:0] word);
      console_reply_t      want;
      logic [CURSOR_W-1:0] got_cursor;
      logic [CELL_W-1:0]   got_cell;
      logic                got_scrolled;
      got_cursor   = word[CURSOR_W-1:0];
      got_cell     = word[CURSOR_W +: CELL_W];
      got_scrolled = word[CURSOR_W + CELL_W];
      if (replies_due.size() == 0) begin
        errors++;
        $error("result word %h arrived with no command outstanding", word);
        return;
      end
      want = replies_due.pop_front();
      checked++;
      if (got_cursor !== want.cursor) begin
        errors++;
        $error("cursor_position: expected %0d, got %0d", want.cursor, got_cursor);
      end
      if (got_cell !== want.cell_value) begin
        errors++;
        $error("cell_value: expected %h, got %h", want.cell_value, got_cell);
      end
      if (got_scrolled !== want.scrolled) begin
        errors++;
        $error("scrolled: expected %0b, got %0b", want.scrolled, got_scrolled);
      end
    endfunction
  endclass

endpackage

FILE: verif/tb.sv
// ---------------------------------------------------------------------------
// Text console character writer testbench
// Drives put, clear, read and unused commands in bursts, stalls the result
// side on its own pattern and checks every result against a screen mirror.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;
  import tcw_scoreboard_pkg::*;

  localparam int     CLK_PERIOD  = 8;
  localparam int     WORD_TARGET = 1550;
  // Worst case is a scroll on every word plus the longest sender gap and
  // result stall, taken a few times over.
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam int     TAIL_CYCLES = 16;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [1:0] opcode, [9:2] char_code, [20:10] cell_index, [23:21] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [10:0] cursor_position, [26:11] cell_value, [27] scrolled, [31:28] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  console_scoreboard board;
  int unsigned       words_sent = 0;
  int unsigned       burst_left = 0;
  longint            cycles     = 0;
  int unsigned       rx_mode    = 0;
  int unsigned       rx_stretch = 0;

  text_console_char_writer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: give up if the block stops answering
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               board.replies_due.size());
      $display("[text_console_char_writer] ERROR");
      $finish;
    end
  end

  // Result side: check each accepted word, then choose the next ready value.
  // The stall pattern switches between always ready, mostly ready and mostly
  // stalled for stretches of random length.
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) board.check_reply(m_axis_tdata);
    if (rx_stretch == 0) begin
      rx_mode    = $urandom_range(0, 2);
      rx_stretch = $urandom_range(16, 160);
    end else begin
      rx_stretch--;
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [IN_DATA_W-1:0] pack_cmd(op_t op, logic [CH_W-1:0] ch,
                                                    logic [IDX_W-1:0] idx);
    return {{(IN_DATA_W - OP_W - CH_W - IDX_W){1'b0}}, idx, ch, op};
  endfunction

  // Present one word and hold it until the block takes it. Between bursts,
  // tvalid may drop for a random gap so that idle cycles land on every phase.
  task automatic send_word(input logic [IN_DATA_W-1:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 5))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(10, 30);
        default: gap = $urandom_range(1, 5);
      endcase
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    board.note_command(word);
    words_sent++;
  endtask

  // Fields unused by a command carry random values so that their bits toggle
  task automatic put_char(input logic [CH_W-1:0] ch);
    send_word(pack_cmd(OP_PUT, ch, IDX_W'($urandom_range(0, 2047))));
  endtask

  task automatic read_cell(input logic [IDX_W-1:0] idx);
    send_word(pack_cmd(OP_READ, CH_W'($urandom_range(0, 255)), idx));
  endtask

  task automatic clear_screen();
    send_word(pack_cmd(OP_CLEAR, CH_W'($urandom_range(0, 255)),
                       IDX_W'($urandom_range(0, 2047))));
  endtask

  function automatic logic [CH_W-1:0] control_char();
    case ($urandom_range(0, 2))
      0:       return CH_NEWLINE;
      1:       return CH_RETURN;
      default: return CH_BACKSPACE;
    endcase
  endfunction

  // Favour the bottom row, where text lands once the screen has scrolled
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return IDX_W'($urandom_range(LAST_ROW, SCREEN_SIZE - 1));
    if (roll < 85) return IDX_W'($urandom_range(0, SCREEN_SIZE - 1));
    return IDX_W'($urandom_range(0, 2047));
  endfunction

  // One random sequence: mostly lines of text and read-backs, with newline
  // runs to reach the bottom row, editing keys, clears and some noise.
  task automatic random_sequence();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      len = $urandom_range(1, 60);
      repeat (len) begin
        if ($urandom_range(0, 9) == 0) put_char(control_char());
        else put_char(CH_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 1) put_char(CH_NEWLINE);
    end else if (roll < 55) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 4);
      repeat (len) put_char(CH_NEWLINE);
    end else if (roll < 75) begin
      len = $urandom_range(1, 8);
      repeat (len) read_cell(pick_index());
    end else if (roll < 80) begin
      clear_screen();
    end else if (roll < 90) begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        case ($urandom_range(0, 2))
          0:       put_char(CH_BACKSPACE);
          1:       put_char(CH_RETURN);
          default: put_char(CH_W'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      len = $urandom_range(1, 4);
      repeat (len) begin
        if ($urandom_range(0, 3) != 0)
          send_word(pack_cmd(OP_NONE, CH_W'($urandom_range(0, 255)),
                             IDX_W'($urandom_range(0, 2047))));
        else
          send_word(pack_cmd(op_t'($urandom_range(0, 3)), CH_W'($urandom_range(0, 255)),
                             IDX_W'($urandom_range(0, 2047))));
      end
    end
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Blank screen after reset, last cell, first cell off the screen, top index
    read_cell(0);
    read_cell(IDX_W'(SCREEN_SIZE - 1));
    read_cell(IDX_W'(SCREEN_SIZE));
    read_cell(11'h7FF);
    // Backspace at home must stay put and not scroll
    put_char(CH_BACKSPACE);
    // Character extremes, then read them back
    put_char(8'h41);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(8'h80);
    read_cell(0);
    read_cell(1);
    read_cell(2);
    read_cell(3);
    // Backspace without erasing, return to row start, newline to next row
    put_char(CH_BACKSPACE);
    put_char(CH_RETURN);
    put_char(CH_NEWLINE);
    // Unused opcode with every data bit set
    send_word(pack_cmd(OP_NONE, 8'hFF, 11'h7FF));
    put_char(8'h7E);
    read_cell(IDX_W'(COLUMNS));
    clear_screen();
    read_cell(IDX_W'(COLUMNS));

    while (words_sent < WORD_TARGET) random_sequence();
    s_axis_tvalid <= 1'b0;

    // Drain, then allow a few more cycles for any stray result word
    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d command words, checked %0d results in %0d cycles",
             words_sent, board.checked, cycles);
    $display("puts %0d (scrolls %0d), clears %0d, reads %0d (off-screen %0d), unused %0d",
             board.puts, board.scrolls, board.clears, board.reads, board.wild_reads,
             board.unused_ops);
    if (board.errors == 0) begin
      $display("[text_console_char_writer] OK");
    end else begin
      $display("[text_console_char_writer] ERROR");
    end
    $finish;
  end

endmodule
